FILE: hdl/frx_pkg.sv
// frx_pkg: shared types and constants of the framed packet receiver
// holds the frame request passed from the parser to the drain side
// no dependencies
`default_nettype none

package frx_pkg;

    // depth of the frame request queue between parser and drain
    localparam int QUEUE_DEPTH = 2;

    // packed output data width (fields plus zero fill to whole bytes)
    localparam int OUT_DATA_W = 48;

    // one finished frame, as decided at its checksum byte
    typedef struct packed {
        logic        frame_ok;
        logic [7:0]  seq_byte;
        logic [7:0]  length_byte;
        logic        has_payload;
        logic        bank;
        logic [15:0] err_count;
    } job_t;

    // payload bank handed back by the drain side
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

`default_nettype wire

FILE: hdl/frx_ram.sv
// frx_ram: generic single write port, single read port memory
// registered read data that holds while no read is issued
// no dependencies
`default_nettype none

module frx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/frx_front.sv
// frx_front: byte parser of the framed packet receiver
// hunts for the start byte, sums the frame, stores payload, queues frame requests
// depends on frx_pkg
`default_nettype none

module frx_front #(
    parameter int PAYLOAD_SIZE = 32,
    parameter int IW = (PAYLOAD_SIZE > 1) ? $clog2(PAYLOAD_SIZE) : 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_wr_en,
    input  wire logic [7:0]     cfg_wr_data,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     in_byte,
    output logic                ram_wr_en,
    output logic [IW:0]         ram_wr_addr,
    output logic [7:0]          ram_wr_data,
    output logic                q_push,
    output frx_pkg::job_t       q_job,
    input  wire logic           q_full,
    input  wire frx_pkg::rel_t  rel
);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_SEQ   = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;

    logic [2:0]    phase_reg, phase_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    seq_reg, seq_next;
    logic [7:0]    len_reg, len_next;
    logic [15:0]   err_reg, err_next;
    logic [7:0]    start_reg;
    logic          bank_reg, bank_next;
    logic [1:0]    busy_reg, busy_next;
    logic          accept;
    logic          frame_ok;

    // start byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 8'd2;
        end
        else if (cfg_wr_en)
        begin
            start_reg <= cfg_wr_data;
        end
    end

    // back pressure: payload needs a free bank, checksum needs queue room
    always_comb
    begin
        in_ready = 1'b1;
        if (phase_reg == PH_DATA)
        begin
            in_ready = !busy_reg[bank_reg];
        end
        else if (phase_reg == PH_CHECK)
        begin
            in_ready = !q_full;
        end
    end

    assign accept   = in_valid && in_ready;
    assign frame_ok = (in_byte == sum_reg);

    // payload write
    assign ram_wr_en   = accept && (phase_reg == PH_DATA);
    assign ram_wr_addr = {bank_reg, idx_reg};
    assign ram_wr_data = in_byte;

    // frame request at the checksum byte
    assign q_push            = accept && (phase_reg == PH_CHECK);
    assign q_job.frame_ok    = frame_ok;
    assign q_job.seq_byte    = seq_reg;
    assign q_job.length_byte = len_reg;
    assign q_job.has_payload = frame_ok && (len_reg != 8'd0);
    assign q_job.bank        = bank_reg;
    assign q_job.err_count   = err_next;

    // parser state machine
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (phase_reg == PH_CHECK && !frame_ok)
        begin
            err_next = err_reg + 16'd1;
        end
        if (accept)
        begin
            unique case (phase_reg)
                PH_SEQ:
                begin
                    seq_next   = in_byte;
                    sum_next   = sum_reg + in_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = in_byte;
                    sum_next   = sum_reg + in_byte;
                    phase_next = (in_byte != 8'd0) ? PH_DATA : PH_CHECK;
                end
                PH_DATA:
                begin
                    sum_next = sum_reg + in_byte;
                    if (idx_reg == IW'(PAYLOAD_SIZE - 1))
                    begin
                        idx_next   = '0;
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT;
                    if (q_job.has_payload)
                    begin
                        busy_next[bank_reg] = 1'b1;
                        bank_next           = !bank_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (in_byte == start_reg)
                    begin
                        idx_next   = '0;
                        sum_next   = in_byte;
                        phase_next = PH_SEQ;
                    end
                end
            endcase
        end
        else
        begin
            err_next = err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
            sum_reg   <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            err_reg   <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            seq_reg   <= seq_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/frx_queue.sv
// frx_queue: short fifo of frame requests between parser and drain
// depends on frx_pkg
`default_nettype none

module frx_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire frx_pkg::job_t  push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output frx_pkg::job_t       head
);

    localparam int PW = (frx_pkg::QUEUE_DEPTH > 1) ? $clog2(frx_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(frx_pkg::QUEUE_DEPTH + 1);

    frx_pkg::job_t entry_reg [frx_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == CW'(frx_pkg::QUEUE_DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(frx_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(frx_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/frx_back.sv
// frx_back: drain side of the framed packet receiver
// turns frame requests into results, reading payload banks from the memory
// depends on frx_pkg
`default_nettype none

module frx_back #(
    parameter int PAYLOAD_SIZE = 32,
    parameter int IW = (PAYLOAD_SIZE > 1) ? $clog2(PAYLOAD_SIZE) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_valid,
    input  wire frx_pkg::job_t                     q_job,
    output logic                                   q_pop,
    output logic                                   ram_rd_en,
    output logic [IW:0]                            ram_rd_addr,
    input  wire logic [7:0]                        ram_rd_data,
    output frx_pkg::rel_t                          rel,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [frx_pkg::OUT_DATA_W-1:0]         out_data,
    output logic                                   out_has_payload,
    output logic                                   out_last
);

    localparam int CW = $clog2(PAYLOAD_SIZE + 1);

    frx_pkg::job_t hdr_reg;
    logic          active_reg;
    logic          rd_pend_reg;
    logic [CW-1:0] rd_cnt_reg;
    logic [CW-1:0] ld_cnt_reg;
    logic          out_valid_reg;
    logic [frx_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic          out_has_reg;
    logic          out_last_reg;
    logic          out_free;
    logic          load;
    logic          load_last;
    logic          status_pop;

    assign out_free   = !out_valid_reg || out_ready;
    assign load       = rd_pend_reg && out_free;
    assign load_last  = load && (ld_cnt_reg == CW'(PAYLOAD_SIZE - 1));
    assign ram_rd_en  = active_reg && (rd_cnt_reg != CW'(PAYLOAD_SIZE))
                        && (!rd_pend_reg || load);
    assign ram_rd_addr = {hdr_reg.bank, rd_cnt_reg[IW-1:0]};
    assign q_pop      = q_valid && !active_reg && (q_job.has_payload || out_free);
    assign status_pop = q_pop && !q_job.has_payload;

    assign rel.valid = load_last;
    assign rel.bank  = hdr_reg.bank;

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign out_has_payload = out_has_reg;
    assign out_last        = out_last_reg;

    // header of the frame being drained
    always_ff @(posedge clk)
    begin
        if (q_pop && q_job.has_payload)
        begin
            hdr_reg <= q_job;
        end
    end

    // read sequencing over one payload bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_cnt_reg  <= '0;
            ld_cnt_reg  <= '0;
        end
        else
        begin
            if (q_pop && q_job.has_payload)
            begin
                active_reg <= 1'b1;
                rd_cnt_reg <= '0;
                ld_cnt_reg <= '0;
            end
            else
            begin
                if (ram_rd_en)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (load)
                begin
                    ld_cnt_reg <= ld_cnt_reg + 1'b1;
                end
                if (load_last)
                begin
                    active_reg <= 1'b0;
                end
            end
            if (ram_rd_en)
            begin
                rd_pend_reg <= 1'b1;
            end
            else if (load)
            begin
                rd_pend_reg <= 1'b0;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load || status_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload: tdata = ok, seq, length, payload, count, fill
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= {7'd0, hdr_reg.err_count, ram_rd_data, hdr_reg.length_byte,
                             hdr_reg.seq_byte, 1'b1};
            out_has_reg  <= 1'b1;
            out_last_reg <= load_last;
        end
        else if (status_pop)
        begin
            out_data_reg <= {7'd0, q_job.err_count, 8'd0, q_job.length_byte,
                             q_job.seq_byte, q_job.frame_ok};
            out_has_reg  <= 1'b0;
            out_last_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/framed_packet_receiver.sv
// framed_packet_receiver: byte-serial frame receiver (start, seq, length, payload, checksum)
// top level: parser, request queue, payload memory and drain side
// depends on frx_pkg, frx_ram, frx_front, frx_queue, frx_back
//
//  channel   direction  moves                      handshake
//  s_axis    in         one received byte          tvalid/tready
//  m_axis    out        one result                 tvalid/tready, tlast
//  cfg       in         start byte register        cfg_wr_en, no wait
//
// the parser accepts input bytes whenever it is not stalled; a good frame with payload
// drains PAYLOAD_SIZE results at one per cycle when m_axis is ready, from a two-bank
// payload memory while the parser goes on with the next frame. the parser stalls only
// when both banks hold undrained payload or the request queue is full.
// reset clears parser, queue and drain control; payload memory needs no clearing
// and is not cleared. result stalls on m_axis back up through the queue.
`default_nettype none

module framed_packet_receiver #(
    parameter int PAYLOAD_SIZE = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,   // start_byte
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] frame_ok, [8:1] seq_byte, [16:9] length_byte, [24:17] payload_byte,
    // [40:25] bad_checksum_count, [47:41] zero
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tuser,  // [0] has_payload
    output logic             m_axis_tlast
);

    localparam int IW = (PAYLOAD_SIZE > 1) ? $clog2(PAYLOAD_SIZE) : 1;

    logic           ram_wr_en;
    logic [IW:0]    ram_wr_addr;
    logic [7:0]     ram_wr_data;
    logic           ram_rd_en;
    logic [IW:0]    ram_rd_addr;
    logic [7:0]     ram_rd_data;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    frx_pkg::job_t  push_job;
    frx_pkg::job_t  head_job;
    frx_pkg::rel_t  rel;

    // parser
    frx_front #(
        .PAYLOAD_SIZE (PAYLOAD_SIZE),
        .IW           (IW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .q_push      (q_push),
        .q_job       (push_job),
        .q_full      (q_full),
        .rel         (rel)
    );

    // two payload banks
    frx_ram #(
        .WIDTH (8),
        .DEPTH (2 ** (IW + 1))
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // frame request queue
    frx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_job)
    );

    // drain side
    frx_back #(
        .PAYLOAD_SIZE (PAYLOAD_SIZE),
        .IW           (IW)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_job           (head_job),
        .q_pop           (q_pop),
        .ram_rd_en       (ram_rd_en),
        .ram_rd_addr     (ram_rd_addr),
        .ram_rd_data     (ram_rd_data),
        .rel             (rel),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_data        (m_axis_tdata),
        .out_has_payload (m_axis_tuser),
        .out_last        (m_axis_tlast)
    );

endmodule

`default_nettype wire
